// File: rtl/temporal_led_dither_assert.svh
// Assertion macros used by the temporal LED dither top level.
// No dependencies; pulled in with `include by the top level to check its logic.
`ifndef TEMPORAL_LED_DITHER_ASSERT_SVH
`define TEMPORAL_LED_DITHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TLD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tld assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tld assertion failed");

`endif

// File: rtl/tld_pkg.sv
// Package for the temporal LED dither block: payload structs, codes, widths
// and the per-channel dither function. No dependencies.
`timescale 1ns / 1ps

package tld_pkg;

  localparam int LED_BITS   = 6;                 // LED_COUNT = 64, power of two
  localparam int LED_COUNT  = 1 << LED_BITS;
  localparam int STEP_BITS  = 4;                 // DITHER_STEPS = 16, power of two
  localparam int DITHER_STEPS = 1 << STEP_BITS;
  localparam int LEVEL_W    = 12;
  localparam int PHASE_W    = 6;
  localparam int FRAME_W    = 4;
  localparam int ORDER_BITS = 4;                 // frame-order table depth 16
  localparam int BASE_W     = LEVEL_W - STEP_BITS;
  localparam int SUM_W      = PHASE_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam logic [1:0] ACT_PIXEL      = 2'd0;
  localparam logic [1:0] ACT_LOAD_PHASE = 2'd1;
  localparam logic [1:0] ACT_LOAD_ORDER = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUE_OFFSET  = 1'd1;

  typedef struct packed {
    logic [1:0]         action;
    logic [LED_BITS-1:0] led_index;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [PHASE_W-1:0] load_value;
    logic               last_in_frame;
  } in_item_t;

  typedef struct packed {
    logic [LED_BITS-1:0] out_led;
    logic [7:0]          red_out;
    logic [7:0]          green_out;
    logic [7:0]          blue_out;
  } out_item_t;

  // write request into the frame-order table
  typedef struct packed {
    logic                  we;
    logic [ORDER_BITS-1:0] addr;
    logic [FRAME_W-1:0]    data;
  } order_wr_t;

  // base = level / steps, plus one when the fraction beats the threshold, saturated at 255
  function automatic logic [7:0] dither_chan(input logic [LEVEL_W-1:0] level,
                                             input logic [PHASE_W-1:0] phase,
                                             input logic [FRAME_W-1:0] frame);
    logic [BASE_W-1:0]    base;
    logic [STEP_BITS-1:0] frac;
    logic [STEP_BITS-1:0] thresh;
    logic [SUM_W-1:0]     sum;
    logic [BASE_W:0]      v;
    base   = level[LEVEL_W-1:STEP_BITS];
    frac   = level[STEP_BITS-1:0];
    sum    = SUM_W'(phase) + SUM_W'(frame);
    thresh = sum[STEP_BITS-1:0];
    v      = {1'b0, base} + (BASE_W+1)'(frac > thresh);
    return (v > (BASE_W+1)'(255)) ? 8'hFF : v[7:0];
  endfunction

endpackage

// File: rtl/tld_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tld_ram #(
  parameter int AW = 6,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [1 << AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tld_frame.sv
// Frame sequencer: frame position, frame-order table and current frame value.
// Depends on tld_pkg and tld_ram.
`timescale 1ns / 1ps

module tld_frame (
  input  logic                        clk,
  input  logic                        rst,
  input  tld_pkg::order_wr_t          order_wr,
  input  logic                        advance,
  output logic [tld_pkg::FRAME_W-1:0] frame_value
);

  logic [tld_pkg::STEP_BITS-1:0]  frame_pos;
  logic [tld_pkg::STEP_BITS-1:0]  frame_pos_next;
  logic [tld_pkg::FRAME_W-1:0]    frame_reg;
  logic [tld_pkg::FRAME_W-1:0]    order_rdata;
  logic                           pending;

  // wraps at DITHER_STEPS by width
  assign frame_pos_next = frame_pos + 1'b1;

  // table is read every cycle at the next frame slot; after an advance the
  // registered read data is the new frame value for one cycle
  tld_ram #(.AW(tld_pkg::ORDER_BITS), .DW(tld_pkg::FRAME_W)) u_order_ram (
    .clk   (clk),
    .we    (order_wr.we),
    .waddr (order_wr.addr),
    .wdata (order_wr.data),
    .re    (1'b1),
    .raddr (tld_pkg::ORDER_BITS'(frame_pos_next)),
    .rdata (order_rdata)
  );

  assign frame_value = pending ? order_rdata : frame_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos <= '0;
      frame_reg <= '0;
      pending   <= 1'b0;
    end else begin
      frame_reg <= frame_value;
      pending   <= advance;
      if (advance) begin
        frame_pos <= frame_pos_next;
      end
    end
  end

endmodule

// File: rtl/temporal_led_dither.sv
// Temporal LED dither top level: input handshake, phase table copies,
// read stage and output register. Depends on tld_pkg, tld_ram, tld_frame.
//
// Usage: items enter on in_valid/in_ready with an in_item_t payload. Action
// pixel gives one result beat on out_valid/out_ready; load actions write the
// phase table or the frame-order table and give nothing; action 3 is dropped.
// Configuration: cfg_we with cfg_index selects the green or blue phase offset;
// write only while idle.
// Path: an accepted pixel and its phase reads are registered in the read stage,
// then in the output register, which drives out_valid.
// Throughput: one item per clock unless stalled. Three phase table copies
// let the red, green and blue phases be read in the same cycle, one port each.
// Reset (rst, synchronous): clears frame position, frame value, offsets and
// the pipeline valids; table contents are undefined until loaded.
// Stall: while out_valid is high and out_ready is low the output register holds;
// one more pixel waits in the read stage, after which in_ready drops.
`timescale 1ns / 1ps
`include "temporal_led_dither_assert.svh"

module temporal_led_dither (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tld_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tld_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [tld_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tld_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [tld_pkg::LED_BITS-1:0] green_off;
  logic [tld_pkg::LED_BITS-1:0] blue_off;

  logic in_accept;
  logic px_accept;
  logic phase_we;
  logic s1_adv;

  logic                          s1_valid;
  logic [tld_pkg::LED_BITS-1:0]  s1_led;
  logic [tld_pkg::LEVEL_W-1:0]   s1_red;
  logic [tld_pkg::LEVEL_W-1:0]   s1_green;
  logic [tld_pkg::LEVEL_W-1:0]   s1_blue;
  logic [tld_pkg::FRAME_W-1:0]   s1_frame;

  logic [tld_pkg::PHASE_W-1:0]   red_phase;
  logic [tld_pkg::PHASE_W-1:0]   green_phase;
  logic [tld_pkg::PHASE_W-1:0]   blue_phase;
  logic [tld_pkg::LED_BITS-1:0]  green_addr;
  logic [tld_pkg::LED_BITS-1:0]  blue_addr;

  logic [tld_pkg::FRAME_W-1:0]   frame_value;
  tld_pkg::order_wr_t            order_wr;
  tld_pkg::out_item_t            result;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      green_off <= '0;
      blue_off  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tld_pkg::CFG_GREEN_OFFSET: green_off <= cfg_data;
        tld_pkg::CFG_BLUE_OFFSET:  blue_off  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_adv    = !out_valid || out_ready;
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;
  assign px_accept = in_accept && (in_data.action == tld_pkg::ACT_PIXEL);
  assign phase_we  = in_accept && (in_data.action == tld_pkg::ACT_LOAD_PHASE);

  assign order_wr.we   = in_accept && (in_data.action == tld_pkg::ACT_LOAD_ORDER);
  assign order_wr.addr = in_data.led_index[tld_pkg::ORDER_BITS-1:0];
  assign order_wr.data = in_data.load_value[tld_pkg::FRAME_W-1:0];

  // index plus offset wraps at LED_COUNT by width
  assign green_addr = in_data.led_index + green_off;
  assign blue_addr  = in_data.led_index + blue_off;

  tld_ram #(.AW(tld_pkg::LED_BITS), .DW(tld_pkg::PHASE_W)) u_phase_red (
    .clk   (clk),
    .we    (phase_we),
    .waddr (in_data.led_index),
    .wdata (in_data.load_value),
    .re    (px_accept),
    .raddr (in_data.led_index),
    .rdata (red_phase)
  );

  tld_ram #(.AW(tld_pkg::LED_BITS), .DW(tld_pkg::PHASE_W)) u_phase_green (
    .clk   (clk),
    .we    (phase_we),
    .waddr (in_data.led_index),
    .wdata (in_data.load_value),
    .re    (px_accept),
    .raddr (green_addr),
    .rdata (green_phase)
  );

  tld_ram #(.AW(tld_pkg::LED_BITS), .DW(tld_pkg::PHASE_W)) u_phase_blue (
    .clk   (clk),
    .we    (phase_we),
    .waddr (in_data.led_index),
    .wdata (in_data.load_value),
    .re    (px_accept),
    .raddr (blue_addr),
    .rdata (blue_phase)
  );

  tld_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .order_wr    (order_wr),
    .advance     (px_accept && in_data.last_in_frame),
    .frame_value (frame_value)
  );

  // read stage: payload waits here while the phase reads complete
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (px_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (px_accept) begin
      s1_led   <= in_data.led_index;
      s1_red   <= in_data.red_level;
      s1_green <= in_data.green_level;
      s1_blue  <= in_data.blue_level;
      s1_frame <= frame_value;
    end
  end

  always_comb begin
    result.out_led   = s1_led;
    result.red_out   = tld_pkg::dither_chan(s1_red, red_phase, s1_frame);
    result.green_out = tld_pkg::dither_chan(s1_green, green_phase, s1_frame);
    result.blue_out  = tld_pkg::dither_chan(s1_blue, blue_phase, s1_frame);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      out_data <= result;
    end
  end

  `TLD_ASSERT_NEXT(a_px_fills_stage, clk, rst, px_accept, s1_valid)
  `TLD_ASSERT_NOW(a_full_blocks_input, clk, rst, s1_valid && out_valid && !out_ready, !in_ready)
  `TLD_ASSERT_NEXT(a_stage_moves_out, clk, rst, s1_valid && s1_adv, out_valid)
  `TLD_ASSERT_NEXT(a_stall_holds_stage, clk, rst, s1_valid && !s1_adv,
                   s1_valid && $stable(s1_led) && $stable(s1_frame))

endmodule
